### hdl/assert_macros.svh
// Shared assertion macros; assumes clk and arst_n are visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/pfba_pkg.sv
`default_nettype none
package pfba_pkg;
	localparam int MAX_PAGES = 32768;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int MAP_WORDS = MAX_PAGES / WORD_W;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int PAGE_AW   = $clog2(MAX_PAGES);
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int ADDR_W    = 32;
	localparam int PAGE_SHIFT = 12;

	localparam logic [ADDR_W-1:0] BASE_ADDR = 32'h0010_0000;

	localparam logic [CFG_W-1:0] MANAGED_RST = 16'd32768;
	localparam logic [CFG_W-1:0] KERNEL_RST  = 16'd768;

	localparam logic [CFG_IDX_W-1:0] CFG_MANAGED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL  = 1'b1;

	localparam logic [1:0] REQ_KALLOC  = 2'd0;
	localparam logic [1:0] REQ_UALLOC  = 2'd1;
	localparam logic [1:0] REQ_FREE    = 2'd2;
	localparam logic [1:0] REQ_RESERVE = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t ALL_ONES = {WORD_W{1'b1}};

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} ffs_t;

	// lowest set bit of a bitmap word
	function automatic ffs_t find_first(input word_t w);
		ffs_t r;
		r.found = 1'b0;
		r.idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r.found = 1'b1;
				r.idx   = BIT_W'(i);
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

### hdl/pfba_ram.sv
`default_nettype none
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

### hdl/page_frame_bitmap_allocator_unit.sv
`default_nettype none
`include "assert_macros.svh"
// Sequence: free/reserve read the bitmap word on acceptance and write it back in S_MOD; an
//   out-of-range or empty-region request is answered from S_IDLE; allocation scans up to 1024 32-page words.
// A new request may be taken in the strobe cycle, but not before the last one is done; the
//   single-port bitmap RAM, read once per cycle during a scan, sets the pace of allocation.
// Reset: a clearing pass writes zero to the 1024 bitmap words, with busy high;
//   config writes are taken during it. Results cannot be stalled by the receiver.
module page_frame_bitmap_allocator_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        req_type,
	input  wire logic [pfba_pkg::ADDR_W-1:0]       page_address,
	output logic                                   done,
	output logic      [pfba_pkg::ADDR_W-1:0]       result_address,
	output logic      [1:0]                        status,
	input  wire logic                              cfg_we,
	input  wire logic [pfba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfba_pkg::CFG_W-1:0]        cfg_wdata
);
	import pfba_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CLR  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_MOD  = 2'd3;

	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
	localparam logic [CFG_W-1:0]   MAX_CNT   = CFG_W'(MAX_PAGES);

	logic [1:0]             state_q;
	logic [WORD_AW-1:0]     clr_q;
	logic [WORD_AW-1:0]     word_q;
	logic [PAGE_AW-1:0]     lo_q;
	logic [PAGE_AW-1:0]     hi_m1_q;
	logic [PAGE_AW-1:0]     mpage_q;
	logic                   set_q;
	logic [CFG_W-1:0]       managed_q;
	logic [CFG_W-1:0]       kernel_q;
	logic                   done_q;
	logic [ADDR_W-1:0]      result_q;
	logic [1:0]             status_q;

	logic                   ram_we;
	logic [WORD_AW-1:0]     ram_addr;
	word_t                  ram_wdata;
	word_t                  ram_rdata;

	logic [CFG_W-1:0]       eff_m;
	logic [CFG_W-1:0]       eff_k;
	logic [CFG_W-1:0]       lo_n;
	logic [CFG_W-1:0]       hi_n;
	logic [CFG_W-1:0]       hi_m1_n;
	logic                   is_alloc;
	logic                   accept;
	logic                   empty_rgn;
	logic [ADDR_W-1:0]      off;
	logic [ADDR_W-PAGE_SHIFT-1:0] page_n;
	logic                   out_of_rng;
	logic [WORD_AW-1:0]     last_w;
	word_t                  lo_mask;
	word_t                  hi_mask;
	ffs_t                   hit;
	logic [PAGE_AW-1:0]     hit_page;
	logic [ADDR_W-1:0]      hit_addr;
	word_t                  mod_bit;

	pfba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done           = done_q;
	assign result_address = result_q;
	assign status         = status_q;

	// region bounds, clamped as the kernel region may not exceed the managed range
	always_comb begin
		eff_m    = (managed_q > MAX_CNT) ? MAX_CNT : managed_q;
		eff_k    = (kernel_q > eff_m) ? eff_m : kernel_q;
		is_alloc = (req_type == REQ_KALLOC) || (req_type == REQ_UALLOC);
		lo_n     = (req_type == REQ_KALLOC) ? '0 : eff_k;
		hi_n     = (req_type == REQ_KALLOC) ? eff_k : eff_m;
		hi_m1_n  = hi_n - CFG_W'(1);
		empty_rgn = (lo_n >= hi_n);
		off      = page_address - BASE_ADDR;
		page_n   = off[ADDR_W-1:PAGE_SHIFT];
		out_of_rng = (page_address < BASE_ADDR) ||
			(page_n >= (ADDR_W-PAGE_SHIFT)'(eff_m));
	end

	// scan datapath: mask the word to [lo, hi) and pick the lowest free page
	always_comb begin
		last_w   = hi_m1_q[PAGE_AW-1:BIT_W];
		lo_mask  = (word_q == lo_q[PAGE_AW-1:BIT_W]) ? (ALL_ONES << lo_q[BIT_W-1:0]) : ALL_ONES;
		hi_mask  = (word_q == last_w) ?
			(ALL_ONES >> (BIT_W'(WORD_W - 1) - hi_m1_q[BIT_W-1:0])) : ALL_ONES;
		hit      = find_first(~ram_rdata & lo_mask & hi_mask);
		hit_page = {word_q, hit.idx};
		hit_addr = BASE_ADDR + {{(ADDR_W-PAGE_AW-PAGE_SHIFT){1'b0}}, hit_page,
			{PAGE_SHIFT{1'b0}}};
		mod_bit  = word_t'(1) << mpage_q[BIT_W-1:0];
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_addr = is_alloc ? lo_n[PAGE_AW-1:BIT_W] : page_n[PAGE_AW-1:BIT_W];
			end
			S_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			S_SCAN: begin
				if (hit.found) begin
					ram_we    = 1'b1;
					ram_addr  = word_q;
					ram_wdata = ram_rdata | (word_t'(1) << hit.idx);
				end else begin
					ram_addr = word_q + WORD_AW'(1);
				end
			end
			S_MOD: begin
				ram_we    = 1'b1;
				ram_addr  = mpage_q[PAGE_AW-1:BIT_W];
				ram_wdata = set_q ? (ram_rdata | mod_bit) : (ram_rdata & ~mod_bit);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= MANAGED_RST;
			kernel_q  <= KERNEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MANAGED: managed_q <= cfg_wdata;
				CFG_KERNEL:  kernel_q  <= cfg_wdata;
				default:     managed_q <= managed_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
			status_q <= ST_OK;
			word_q   <= '0;
			lo_q     <= '0;
			hi_m1_q  <= '0;
			mpage_q  <= '0;
			set_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + WORD_AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (is_alloc) begin
							result_q <= '0;
							if (empty_rgn) begin
								done_q   <= 1'b1;
								status_q <= ST_NOFREE;
							end else begin
								state_q <= S_SCAN;
								word_q  <= lo_n[PAGE_AW-1:BIT_W];
								lo_q    <= lo_n[PAGE_AW-1:0];
								hi_m1_q <= hi_m1_n[PAGE_AW-1:0];
							end
						end else begin
							result_q <= page_address;
							if (out_of_rng) begin
								done_q   <= 1'b1;
								status_q <= ST_RANGE;
							end else begin
								state_q <= S_MOD;
								mpage_q <= page_n[PAGE_AW-1:0];
								set_q   <= (req_type == REQ_RESERVE);
							end
						end
					end
				end
				S_SCAN: begin
					if (hit.found) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						result_q <= hit_addr;
						status_q <= ST_OK;
					end else if (word_q == last_w) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_NOFREE;
					end else begin
						word_q <= word_q + WORD_AW'(1);
					end
				end
				S_MOD: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= ST_OK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLY(a_done_idle, done_q, state_q == S_IDLE)
	`ASSERT_IMPLY(a_nofree_zero, done_q && status_q == ST_NOFREE, result_q == '0)
	`ASSERT_IMPLY(a_clr_zero, state_q == S_CLR, ram_we && ram_wdata == '0)
	`ASSERT_NEXT(a_scan_ends, state_q == S_SCAN && hit.found, state_q == S_IDLE && done_q)
endmodule
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfba_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [1:0]        status;
	} frame_reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           req_type;
	logic [ADDR_W-1:0]    page_address;
	logic                 done;
	logic [ADDR_W-1:0]    result_address;
	logic [1:0]           status;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// shadow of the allocator: one bit per page, set when the page is used
	bit               frame_used [MAX_PAGES];
	logic [CFG_W-1:0] managed_shadow;
	logic [CFG_W-1:0] kernel_shadow;

	frame_reply_t replies_due[$];
	int           gap_max;
	int           fail_count;
	int           sent_count;
	int           granted_count;
	int           nofree_count;
	int           range_count;
	int           config_count;
	int           stall_cycles;

	page_frame_bitmap_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.page_address(page_address),
		.done(done),
		.result_address(result_address),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic frame_reply_t service_frame_request(input logic [1:0] rt,
			input logic [ADDR_W-1:0] addr);
		frame_reply_t r;
		int managed_eff;
		int kernel_eff;
		int lo;
		int hi;
		logic [ADDR_W-1:0] pg;
		managed_eff = (managed_shadow > MAX_PAGES) ? MAX_PAGES : int'(managed_shadow);
		kernel_eff  = (kernel_shadow > managed_eff) ? managed_eff : int'(kernel_shadow);
		r.addr   = '0;
		r.status = ST_OK;
		if (rt == REQ_KALLOC || rt == REQ_UALLOC) begin
			lo = (rt == REQ_KALLOC) ? 0 : kernel_eff;
			hi = (rt == REQ_KALLOC) ? kernel_eff : managed_eff;
			r.status = ST_NOFREE;
			for (int p = lo; p < hi; p++) begin
				if (!frame_used[p]) begin
					frame_used[p] = 1'b1;
					r.addr   = BASE_ADDR + (ADDR_W'(p) << PAGE_SHIFT);
					r.status = ST_OK;
					break;
				end
			end
		end else begin
			r.addr = addr;
			if (addr < BASE_ADDR) begin
				r.status = ST_RANGE;
			end else begin
				// offset bits within the page do not select anything
				pg = (addr - BASE_ADDR) >> PAGE_SHIFT;
				if (pg >= managed_eff)
					r.status = ST_RANGE;
				else
					frame_used[pg] = (rt == REQ_RESERVE);
			end
		end
		return r;
	endfunction

	// all tasks below are entered and left just after a falling edge
	task automatic send_request(input logic [1:0] rt, input logic [ADDR_W-1:0] addr,
			output frame_reply_t reply);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type     = rt;
		page_address = addr;
		start        = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		reply = service_frame_request(rt, addr);
		replies_due.push_back(reply);
		sent_count++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic wait_idle();
		while (replies_due.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_MANAGED)
			managed_shadow = value;
		else
			kernel_shadow = value;
		config_count++;
	endtask

	task automatic set_regions(input logic [CFG_W-1:0] managed, input logic [CFG_W-1:0] kernel);
		wait_idle();
		write_reg(CFG_MANAGED, managed);
		write_reg(CFG_KERNEL, kernel);
	endtask

	// default regions: allocation order, free/reserve echo, address limits
	task automatic test_basic_requests();
		frame_reply_t r;
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		send_request(REQ_KALLOC, 32'hFFFF_FFFF, r);
		send_request(REQ_UALLOC, 32'h1234_5678, r);
		send_request(REQ_FREE, 32'h0010_0000, r);
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		send_request(REQ_FREE, 32'h0010_5000, r);
		send_request(REQ_RESERVE, 32'h0010_1ABC, r);
		send_request(REQ_RESERVE, 32'h0010_2000, r);
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		send_request(REQ_RESERVE, 32'h080F_FFFF, r);
		send_request(REQ_FREE, 32'h0810_0000, r);
		send_request(REQ_FREE, 32'h000F_FFFF, r);
		send_request(REQ_RESERVE, 32'h0000_0000, r);
		send_request(REQ_RESERVE, 32'hFFFF_FFFF, r);
	endtask

	// empty, oversized and tiny regions
	task automatic test_region_limits();
		frame_reply_t r;
		set_regions(16'd0, 16'd0);
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		send_request(REQ_UALLOC, 32'h0000_0000, r);
		send_request(REQ_FREE, 32'h0010_0000, r);
		set_regions(16'hFFFF, 16'hFFFF);
		send_request(REQ_UALLOC, 32'h0000_0000, r);
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		set_regions(16'd8, 16'd4);
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		send_request(REQ_UALLOC, 32'h0000_0000, r);
		set_regions(16'd32768, 16'd0);
		send_request(REQ_KALLOC, 32'h0000_0000, r);
		send_request(REQ_RESERVE, 32'h0810_0000, r);
	endtask

	task automatic test_random_traffic(input bit full_span, input int n_items);
		frame_reply_t      r;
		logic [ADDR_W-1:0] held[$];
		logic [ADDR_W-1:0] addr;
		logic [1:0]        rt;
		logic [CFG_W-1:0]  m_val;
		logic [CFG_W-1:0]  k_val;
		int                span;
		int                pick;
		int                slot;
		if (full_span) begin
			case ($urandom_range(0, 2))
				0: m_val = 16'd32768;
				1: m_val = 16'hFFFF;
				default: m_val = CFG_W'($urandom_range(32769, 65535));
			endcase
			case ($urandom_range(0, 4))
				0: k_val = 16'd0;
				1: k_val = 16'd32000;
				2: k_val = 16'd32767;
				3: k_val = 16'd32768;
				default: k_val = CFG_W'($urandom_range(0, 65535));
			endcase
		end else begin
			m_val = ($urandom_range(0, 7) == 0) ? 16'd0 : CFG_W'($urandom_range(1, 96));
			case ($urandom_range(0, 3))
				0: k_val = 16'd0;
				1: k_val = m_val;
				2: k_val = m_val + CFG_W'($urandom_range(1, 20));
				default: k_val = CFG_W'($urandom_range(0, int'(m_val)));
			endcase
		end
		set_regions(m_val, k_val);
		span    = (m_val > MAX_PAGES) ? MAX_PAGES : int'(m_val);
		gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				rt = REQ_KALLOC;
			else if (pick < 60)
				rt = REQ_UALLOC;
			else if (pick < 85)
				rt = REQ_FREE;
			else
				rt = REQ_RESERVE;
			addr = $urandom;
			if (rt == REQ_FREE || rt == REQ_RESERVE) begin
				case ($urandom_range(0, 9))
					0: addr = $urandom;
					1: addr = BASE_ADDR - ADDR_W'($urandom_range(1, 4096));
					2, 3, 4: addr = BASE_ADDR + (ADDR_W'($urandom_range(0, span + 1)) << PAGE_SHIFT)
						+ ADDR_W'($urandom_range(0, 4095));
					default: begin
						// otherwise give back a page handed out earlier in this phase, if there is one
						if (held.size() != 0) begin
							slot = $urandom_range(0, held.size() - 1);
							addr = held[slot] | ADDR_W'($urandom_range(0, 4095));
							held.delete(slot);
						end else begin
							addr = BASE_ADDR + (ADDR_W'($urandom_range(0, span + 1)) << PAGE_SHIFT);
						end
					end
				endcase
			end
			send_request(rt, addr, r);
			if ((rt == REQ_KALLOC || rt == REQ_UALLOC) && r.status == ST_OK)
				held.push_back(r.addr);
			if ($urandom_range(0, 39) == 0)
				wait_idle();
		end
	endtask

	always @(posedge clk) begin : check_results
		frame_reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("result with no request outstanding: result_address %h status %0d",
					result_address, status);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (result_address !== want.addr) begin
					$error("result_address: expected %h, actual %h", want.addr, result_address);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				case (want.status)
					ST_OK: granted_count++;
					ST_NOFREE: nofree_count++;
					default: range_count++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		req_type       = REQ_KALLOC;
		page_address   = '0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_MANAGED;
		cfg_wdata      = '0;
		managed_shadow = MANAGED_RST;
		kernel_shadow  = KERNEL_RST;
		gap_max        = 12;
		fail_count     = 0;
		sent_count     = 0;
		granted_count  = 0;
		nofree_count   = 0;
		range_count    = 0;
		config_count   = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// bitmap clearing pass runs with busy high
		wait_idle();

		test_basic_requests();
		test_region_limits();
		for (int ph = 0; ph < 14; ph++)
			test_random_traffic(ph == 1 || ph == 9, (ph == 1 || ph == 9) ? 40 : 60);

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (replies_due.size() != 0) begin
			$error("%0d results never arrived", replies_due.size());
			fail_count++;
		end
		$display("%0d requests over %0d register writes: %0d served, %0d region full, %0d out of range",
			sent_count, config_count, granted_count, nofree_count, range_count);
		$display("regions ranged from empty to beyond the map size, with and without sender gaps");
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire

### page_frame_bitmap_allocator_unit.f
+incdir+hdl
hdl/pfba_pkg.sv
hdl/pfba_ram.sv
hdl/page_frame_bitmap_allocator_unit.sv
sim/tb_top.sv
